// ----- rtl/core/tma_pkg.sv -----
// Shared constants for the triangular moving average unit.
// No dependencies; used by the top level, the divider and the checker.

package tma_pkg;

   localparam int VALUE_W    = 32;
   localparam int TIME_W     = 48;
   localparam int DATA_W     = VALUE_W + TIME_W;
   localparam int HALF_W     = 4;
   localparam int MAX_HALF   = 15;
   localparam int RING_DEPTH = 2 * MAX_HALF + 1;
   localparam int SLOT_W     = $clog2(RING_DEPTH);
   localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
   localparam int WEIGHT_W   = $clog2(MAX_HALF + 2);
   localparam int PROD_W     = VALUE_W + WEIGHT_W;
   localparam int WSUM_W     = $clog2((MAX_HALF + 1) * (MAX_HALF + 1) + 1);
   localparam int PSUM_W     = VALUE_W + WSUM_W;
   localparam int DIV_STEPS  = PSUM_W;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(2);

endpackage

// ----- rtl/core/triangular_moving_average_unit.sv -----
// Top level of the centered triangular moving average unit.
// Depends on tma_pkg and instantiates tma_divider.
//
// Usage: samples enter on the req_ channel, one item each, with the price and
// timestamp in req_tdata and the end-of-series mark on req_tlast. Averages
// leave on the rsp_ channel with the center timestamp, and rsp_tlast marks the
// final average of a series. The half window, two after reset, must be written
// through csr_wr_en and csr_wr_data only while idle; the unit does not enforce this.
// A sample is stored in the value and time rings in the cycle it is accepted.
// Each pending average then passes through a setup step, one ring read per
// window tap (2*D+1 taps at most for half window D, read one at a time
// through the single read port of the value ring), a drain of the multiply
// pipeline, the bit-serial divider and a load of the output register.
// An item that releases no average leaves the unit idle and ready; one that
// releases N averages keeps req_tready low until the last of them has been
// loaded into the output register.
// The result register lets the unit take the next sample while the last
// average still waits for rsp_tready. A stalled receiver holds rsp_tdata and
// rsp_tlast steady and, once a second average is ready, holds the unit until
// the first is taken.
// Reset clears the series counters, the ring pointer and the output valid;
// the ring contents are not cleared, since an entry is never read before it
// has been written in the current series.

module triangular_moving_average_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [31:0] sample_value, [79:32] sample_time
   input  logic [tma_pkg::DATA_W-1:0]    req_tdata,
   // series_end
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [31:0] avg_value, [79:32] avg_time
   output logic [tma_pkg::DATA_W-1:0]    rsp_tdata,
   // run_last
   output logic                          rsp_tlast,
   input  logic                          csr_wr_en,
   input  logic [tma_pkg::HALF_W-1:0]    csr_wr_data
);
   import tma_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SETUP  = 6'b000010,
      ST_TAPS   = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_OUTPUT = 6'b100000
   } state_type;

   // Ring slot of the sample that is 'age' items older than the newest one.
   function automatic logic [SLOT_W-1:0] slot_of_age(input logic [SLOT_W-1:0] wslot,
                                                     input logic [SLOT_W-1:0] age);
      logic [SLOT_W:0] s;
      s = {1'b0, wslot} + (SLOT_W+1)'(RING_DEPTH - 1) - {1'b0, age};
      if (s >= (SLOT_W+1)'(RING_DEPTH)) begin
         s = s - (SLOT_W+1)'(RING_DEPTH);
      end
      return s[SLOT_W-1:0];
   endfunction

   // Sample storage: one write port at accept, one read port per ring.
   logic [VALUE_W-1:0] value_ram [RING_DEPTH];
   logic [TIME_W-1:0]  time_ram  [RING_DEPTH];

   state_type          state_ff, state_in;
   logic [HALF_W-1:0]  half_window_ff;
   logic [SLOT_W-1:0]  write_slot_ff, write_slot_in;
   logic [COUNT_W-1:0] seen_ff, seen_in;
   logic [COUNT_W-1:0] centre_ff, centre_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               end_ff, end_in;
   logic [HALF_W-1:0]  half_ff, half_in;
   logic [HALF_W-1:0]  age_ff, age_in;
   logic [SLOT_W-1:0]  tap_ff, tap_in;
   logic [SLOT_W-1:0]  hi_ff, hi_in;
   logic [WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [PSUM_W-1:0]  psum_ff, psum_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [WEIGHT_W-1:0] rd_weight_ff, rd_weight_in;
   logic               prod_valid_ff, prod_valid_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [VALUE_W-1:0] value_rd_ff;
   logic [TIME_W-1:0]  time_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic               ram_wr_en;
   logic [SLOT_W-1:0]  value_rd_addr;
   logic               time_rd_en;
   logic [SLOT_W-1:0]  time_rd_addr;
   logic               rd_issue;
   logic [WEIGHT_W-1:0] tap_weight;
   logic [SLOT_W-1:0]  tap_dist;
   logic [COUNT_W-1:0] seen_next;
   logic [COUNT_W-1:0] centre_inc;
   logic [COUNT_W-1:0] centre_next;
   logic [COUNT_W-1:0] emit_count;
   logic [HALF_W-1:0]  setup_age;
   logic [HALF_W-1:0]  setup_lo;
   logic [SLOT_W-1:0]  setup_hi_raw;
   logic [SLOT_W-1:0]  setup_newest;
   logic               div_start;
   logic               div_done;
   logic [VALUE_W-1:0] div_quotient;

   assign req_tready = state_ff == ST_IDLE;
   assign accept     = req_tvalid && req_tready;
   assign ram_wr_en  = accept;

   // Counter updates for an accepted sample. The half window register is only
   // four bits wide, so it never exceeds the largest supported half window.
   assign seen_next   = (seen_ff == COUNT_W'(RING_DEPTH)) ? seen_ff : seen_ff + COUNT_W'(1);
   assign centre_inc  = centre_ff + COUNT_W'(1);
   assign centre_next = (centre_inc > seen_next) ? seen_next : centre_inc;
   always_comb begin
      if (req_tlast) begin
         emit_count = centre_next;
      end else if (centre_next > COUNT_W'(half_window_ff)) begin
         emit_count = centre_next - COUNT_W'(half_window_ff);
      end else begin
         emit_count = '0;
      end
   end

   // Window bounds for the center about to be averaged. Right neighbors that
   // have not been seen (past the series end) are clipped off here.
   assign setup_age    = HALF_W'(centre_ff - COUNT_W'(1));
   assign setup_lo     = (setup_age > half_ff) ? setup_age - half_ff : '0;
   assign setup_hi_raw = SLOT_W'(setup_age) + SLOT_W'(half_ff);
   assign setup_newest = SLOT_W'(seen_ff - COUNT_W'(1));

   // Triangular weight of the tap being read: D - |tap - age| + 1.
   assign tap_dist   = (tap_ff > SLOT_W'(age_ff)) ? tap_ff - SLOT_W'(age_ff)
                                                  : SLOT_W'(age_ff) - tap_ff;
   assign tap_weight = WEIGHT_W'(half_ff) - WEIGHT_W'(tap_dist) + WEIGHT_W'(1);

   assign value_rd_addr = slot_of_age(write_slot_ff, tap_ff);
   assign time_rd_addr  = slot_of_age(write_slot_ff, SLOT_W'(setup_age));

   always_comb begin
      state_in      = state_ff;
      write_slot_in = write_slot_ff;
      seen_in       = seen_ff;
      centre_in     = centre_ff;
      remain_in     = remain_ff;
      end_in        = end_ff;
      half_in       = half_ff;
      age_in        = age_ff;
      tap_in        = tap_ff;
      hi_in         = hi_ff;
      wsum_in       = wsum_ff;
      psum_in       = prod_valid_ff ? psum_ff + PSUM_W'(prod_ff) : psum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      time_rd_en    = 1'b0;
      rd_issue      = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               write_slot_in = (write_slot_ff == SLOT_W'(RING_DEPTH - 1))
                               ? '0 : write_slot_ff + SLOT_W'(1);
               seen_in   = seen_next;
               centre_in = centre_next;
               remain_in = emit_count;
               end_in    = req_tlast;
               half_in   = half_window_ff;
               if (emit_count != '0) begin
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            age_in     = setup_age;
            tap_in     = SLOT_W'(setup_lo);
            hi_in      = (setup_hi_raw > setup_newest) ? setup_newest : setup_hi_raw;
            wsum_in    = '0;
            psum_in    = '0;
            time_rd_en = 1'b1;
            state_in   = ST_TAPS;
         end
         ST_TAPS: begin
            rd_issue = 1'b1;
            wsum_in  = wsum_ff + WSUM_W'(tap_weight);
            if (tap_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end else begin
               tap_in = tap_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            // Wait until the last product has been added in.
            if (!rd_valid_ff && !prod_valid_ff) begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {time_rd_ff, div_quotient};
               rsp_last_in  = end_ff && (remain_ff == COUNT_W'(1));
               centre_in    = centre_ff - COUNT_W'(1);
               remain_in    = remain_ff - COUNT_W'(1);
               if (remain_ff == COUNT_W'(1)) begin
                  state_in = ST_IDLE;
                  if (end_ff) begin
                     write_slot_in = '0;
                     seen_in       = '0;
                     centre_in     = '0;
                  end
               end else begin
                  state_in = ST_SETUP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Multiply pipeline: ring read, then weight times value, then accumulate.
   assign rd_valid_in   = rd_issue;
   assign rd_weight_in  = tap_weight;
   assign prod_valid_in = rd_valid_ff;
   assign prod_in       = PROD_W'(rd_weight_ff) * PROD_W'(value_rd_ff);

   always_ff @(posedge clock) begin
      if (ram_wr_en) begin
         value_ram[write_slot_ff] <= req_tdata[VALUE_W-1:0];
         time_ram[write_slot_ff]  <= req_tdata[DATA_W-1:VALUE_W];
      end
      value_rd_ff <= value_ram[value_rd_addr];
      if (time_rd_en) begin
         time_rd_ff <= time_ram[time_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         half_window_ff <= HALF_RESET;
         write_slot_ff  <= '0;
         seen_ff        <= '0;
         centre_ff      <= '0;
         remain_ff      <= '0;
         rd_valid_ff    <= 1'b0;
         prod_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            half_window_ff <= csr_wr_data;
         end
         write_slot_ff <= write_slot_in;
         seen_ff       <= seen_in;
         centre_ff     <= centre_in;
         remain_ff     <= remain_in;
         rd_valid_ff   <= rd_valid_in;
         prod_valid_ff <= prod_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      end_ff       <= end_in;
      half_ff      <= half_in;
      age_ff       <= age_in;
      tap_ff       <= tap_in;
      hi_ff        <= hi_in;
      wsum_ff      <= wsum_in;
      psum_ff      <= psum_in;
      rd_weight_ff <= rd_weight_in;
      prod_ff      <= prod_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   tma_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (psum_ff),
      .divisor  (wsum_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- rtl/core/tma_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the moving average unit.
// Depends on tma_pkg for the dividend, divisor and quotient widths.

module tma_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tma_pkg::PSUM_W-1:0]    dividend,
   input  logic [tma_pkg::WSUM_W-1:0]    divisor,
   output logic                          done,
   output logic [tma_pkg::VALUE_W-1:0]   quotient
);
   import tma_pkg::*;

   logic [PSUM_W-1:0] quo_ff, quo_in;
   logic [WSUM_W-1:0] rem_ff, rem_in;
   logic [WSUM_W-1:0] divisor_ff, divisor_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WSUM_W:0]   trial;
   logic [WSUM_W:0]   diff;
   logic              fits;

   // The remainder always stays below the divisor, so the shifted trial value
   // fits one extra bit and the difference fits back into the remainder.
   assign trial = {rem_ff, quo_ff[PSUM_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      step_in    = step_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         quo_in     = dividend;
         rem_in     = '0;
         divisor_in = divisor;
         step_in    = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[WSUM_W-1:0] : trial[WSUM_W-1:0];
         quo_in  = {quo_ff[PSUM_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      step_ff    <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[VALUE_W-1:0];

endmodule

// ----- rtl/core/tma_checker.sv -----
// Port-level checks for the triangular moving average unit, with the bind
// that attaches them to the top level. Depends on tma_pkg.

module tma_port_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_tvalid,
   input logic                        req_tready,
   input logic                        req_tlast,
   input logic                        rsp_tvalid,
   input logic                        rsp_tready,
   input logic [tma_pkg::DATA_W-1:0]  rsp_tdata,
   input logic                        rsp_tlast
);
   import tma_pkg::*;

   // A result held back by the receiver keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A new result only appears after the unit has been busy computing it.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while the unit was idle");

   // The last item of a series always releases at least one result.
   a_end_flushes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("series end did not start a flush");

endmodule

bind triangular_moving_average_unit tma_port_checker u_tma_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
